// ===== sv/dcm_pkg.sv =====
`default_nettype none
package dcm_pkg;

	localparam int VEC_W = 32;
	localparam int DIM = 3;
	localparam int FUNC_W = 3;
	localparam int ROW_W = 2;
	localparam int USER_IN_W = FUNC_W + ROW_W;
	localparam int TDATA_W = DIM * VEC_W;
	localparam logic [ROW_W-1:0] ROW_NONE = 2'd3;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD,
		FN_ZERO,
		FN_IDENT,
		FN_ROT,
		FN_ROT_XY,
		FN_ROT_XY_INV,
		FN_MUL,
		FN_MUL_T
	} func_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_ZERO,
		OP_IDENT,
		OP_ROT,
		OP_MUL,
		OP_MULT
	} op_t;

	typedef struct packed {
		op_t op;
		logic [ROW_W-1:0] row;
		logic inv;
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [VEC_W-1:0] vz;
	} cmd_t;

endpackage
`default_nettype wire

// ===== sv/dcm_front.sv =====
`default_nettype none
module dcm_front (
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [dcm_pkg::TDATA_W-1:0]  s_tdata,   // vec_x, vec_y, vec_z
	input  logic [dcm_pkg::USER_IN_W-1:0] s_tuser,  // func, row_sel
	output logic                         push_valid,
	input  logic                         push_ready,
	output dcm_pkg::cmd_t                push_cmd
);
	import dcm_pkg::*;

	func_t fn;
	logic [ROW_W-1:0] row_sel;

	assign fn = func_t'(s_tuser[FUNC_W-1:0]);
	assign row_sel = s_tuser[USER_IN_W-1:FUNC_W];
	assign push_valid = s_tvalid;
	assign s_tready = push_ready;

	always_comb begin
		push_cmd.row = row_sel;
		push_cmd.inv = 1'b0;
		push_cmd.vx = s_tdata[VEC_W-1:0];
		push_cmd.vy = s_tdata[2*VEC_W-1:VEC_W];
		push_cmd.vz = s_tdata[3*VEC_W-1:2*VEC_W];
		case (fn)
			FN_LOAD: begin
				push_cmd.op = (row_sel == ROW_NONE) ? OP_NOP : OP_LOAD;
			end
			FN_ZERO: begin
				push_cmd.op = OP_ZERO;
			end
			FN_IDENT: begin
				push_cmd.op = OP_IDENT;
			end
			FN_ROT: begin
				push_cmd.op = OP_ROT;
			end
			FN_ROT_XY: begin
				push_cmd.op = OP_ROT;
				push_cmd.vz = '0;
			end
			FN_ROT_XY_INV: begin
				push_cmd.op = OP_ROT;
				push_cmd.vz = '0;
				push_cmd.inv = 1'b1;
			end
			FN_MUL: begin
				push_cmd.op = OP_MUL;
			end
			FN_MUL_T: begin
				push_cmd.op = OP_MULT;
			end
			default: begin
				push_cmd.op = OP_NOP;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/dcm_queue.sv =====
`default_nettype none
module dcm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  dcm_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output dcm_pkg::cmd_t pop_cmd
);
	import dcm_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// ===== sv/dcm_back.sv =====
`default_nettype none
module dcm_back #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS = 28
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  dcm_pkg::cmd_t                     in_cmd,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic signed [dcm_pkg::VEC_W-1:0]  out_x,
	output logic signed [dcm_pkg::VEC_W-1:0]  out_y,
	output logic signed [dcm_pkg::VEC_W-1:0]  out_z,
	output logic                              saturated
);
	import dcm_pkg::*;

	localparam int EW = ELEM_WIDTH;
	localparam int PW = ELEM_WIDTH + VEC_W;
	localparam int SLOTS = 2 * DIM;

	typedef logic signed [EW-1:0] elem_t;
	typedef logic signed [PW-1:0] wide_t;
	typedef logic signed [VEC_W-1:0] vec_t;

	localparam elem_t EMAX = {1'b0, {(EW-1){1'b1}}};
	localparam wide_t PW_EMAX = {{(PW-EW+1){1'b0}}, {(EW-1){1'b1}}};
	localparam wide_t PW_EMIN = {{(PW-EW+1){1'b1}}, {(EW-1){1'b0}}};
	localparam wide_t PW_VMAX = {{(PW-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}};
	localparam wide_t PW_VMIN = {{(PW-VEC_W+1){1'b1}}, {(VEC_W-1){1'b0}}};
	localparam elem_t ONE_E = (FRAC_BITS >= EW - 1) ? EMAX : EW'(64'd1 << FRAC_BITS);

	function automatic wide_t ext_e(input elem_t a);
		return PW'(a);
	endfunction

	function automatic wide_t ext_v(input vec_t a);
		return PW'(a);
	endfunction

	// The top bit of the result flags a clip.
	function automatic logic [EW:0] sat_e(input wide_t v);
		logic [EW:0] r;
		if (v > PW_EMAX) begin
			r = {1'b1, PW_EMAX[EW-1:0]};
		end else if (v < PW_EMIN) begin
			r = {1'b1, PW_EMIN[EW-1:0]};
		end else begin
			r = {1'b0, v[EW-1:0]};
		end
		return r;
	endfunction

	function automatic logic [VEC_W:0] sat_v(input wide_t v);
		logic [VEC_W:0] r;
		if (v > PW_VMAX) begin
			r = {1'b1, PW_VMAX[VEC_W-1:0]};
		end else if (v < PW_VMIN) begin
			r = {1'b1, PW_VMIN[VEC_W-1:0]};
		end else begin
			r = {1'b0, v[VEC_W-1:0]};
		end
		return r;
	endfunction

	function automatic logic [EW:0] scale_p(input wide_t p);
		wide_t s;
		s = p >>> FRAC_BITS;
		return sat_e(s);
	endfunction

	function automatic logic writes_mtx(input op_t op);
		return (op == OP_LOAD) || (op == OP_ZERO) || (op == OP_IDENT) || (op == OP_ROT);
	endfunction

	function automatic logic reads_mtx(input op_t op);
		return (op == OP_ROT) || (op == OP_MUL) || (op == OP_MULT);
	endfunction

	elem_t mtx_q [DIM][DIM];

	logic valid_s1;
	op_t op_s1;
	logic [ROW_W-1:0] row_s1;
	logic inv_s1;
	vec_t vec_s1 [DIM];
	wide_t prod_s1 [DIM][SLOTS];

	logic out_valid_q;
	vec_t out_q [DIM];
	logic sat_q;

	vec_t vin [DIM];
	elem_t opa [DIM][SLOTS];
	vec_t opb [DIM][SLOTS];
	wide_t prod [DIM][SLOTS];

	logic [EW:0] pc [DIM][SLOTS];
	elem_t rot_new [DIM][DIM];
	logic rot_sat;
	elem_t ld_val [DIM];
	logic ld_sat;
	vec_t mul_out [DIM];
	logic mul_sat;
	logic is_mul;
	logic res_sat;

	logic adv;
	logic hazard;
	logic take;

	assign adv = valid_s1 && (!out_valid_q || m_tready);
	assign hazard = valid_s1 && writes_mtx(op_s1) && reads_mtx(in_cmd.op);
	assign in_ready = (!valid_s1 || adv) && !hazard;
	assign take = in_valid && in_ready;

	assign vin[0] = in_cmd.vx;
	assign vin[1] = in_cmd.vy;
	assign vin[2] = in_cmd.vz;

	// Rotate slots per row hold the cross products (p, q) for x, y and z.
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			for (int j = 0; j < SLOTS; j++) begin
				opa[r][j] = '0;
				opb[r][j] = '0;
			end
			case (in_cmd.op)
				OP_MUL: begin
					for (int c = 0; c < DIM; c++) begin
						opa[r][c] = mtx_q[r][c];
						opb[r][c] = vin[c];
					end
				end
				OP_MULT: begin
					for (int c = 0; c < DIM; c++) begin
						opa[r][c] = mtx_q[r][c];
						opb[r][c] = vin[r];
					end
				end
				default: begin
					opa[r][0] = mtx_q[r][1];
					opb[r][0] = in_cmd.vz;
					opa[r][1] = mtx_q[r][2];
					opb[r][1] = in_cmd.vy;
					opa[r][2] = mtx_q[r][2];
					opb[r][2] = in_cmd.vx;
					opa[r][3] = mtx_q[r][0];
					opb[r][3] = in_cmd.vz;
					opa[r][4] = mtx_q[r][0];
					opb[r][4] = in_cmd.vy;
					opa[r][5] = mtx_q[r][1];
					opb[r][5] = in_cmd.vx;
				end
			endcase
			for (int j = 0; j < SLOTS; j++) begin
				prod[r][j] = opa[r][j] * opb[r][j];
			end
		end
	end

	always_comb begin
		logic [EW:0] cr;
		logic [EW:0] nv;
		logic [EW:0] sum1;
		logic [EW:0] sum2;
		logic [EW:0] lv;
		logic [VEC_W:0] oc;
		logic [EW:0] tk [DIM];

		rot_sat = 1'b0;
		mul_sat = 1'b0;
		ld_sat = 1'b0;
		for (int r = 0; r < DIM; r++) begin
			for (int j = 0; j < SLOTS; j++) begin
				pc[r][j] = scale_p(prod_s1[r][j]);
			end
		end

		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				if (inv_s1) begin
					cr = sat_e(ext_e(pc[r][2*c+1][EW-1:0]) - ext_e(pc[r][2*c][EW-1:0]));
				end else begin
					cr = sat_e(ext_e(pc[r][2*c][EW-1:0]) - ext_e(pc[r][2*c+1][EW-1:0]));
				end
				nv = sat_e(ext_e(mtx_q[r][c]) + ext_e(cr[EW-1:0]));
				rot_new[r][c] = nv[EW-1:0];
				rot_sat = rot_sat | pc[r][2*c][EW] | pc[r][2*c+1][EW] | cr[EW] | nv[EW];
			end
		end

		for (int i = 0; i < DIM; i++) begin
			for (int k = 0; k < DIM; k++) begin
				tk[k] = (op_s1 == OP_MULT) ? pc[k][i] : pc[i][k];
				mul_sat = mul_sat | tk[k][EW];
			end
			sum1 = sat_e(ext_e(tk[0][EW-1:0]) + ext_e(tk[1][EW-1:0]));
			sum2 = sat_e(ext_e(sum1[EW-1:0]) + ext_e(tk[2][EW-1:0]));
			oc = sat_v(ext_e(sum2[EW-1:0]));
			mul_out[i] = oc[VEC_W-1:0];
			mul_sat = mul_sat | sum1[EW] | sum2[EW] | oc[VEC_W];
		end

		for (int c = 0; c < DIM; c++) begin
			lv = sat_e(ext_v(vec_s1[c]));
			ld_val[c] = lv[EW-1:0];
			ld_sat = ld_sat | lv[EW];
		end
	end

	always_comb begin
		is_mul = 1'b0;
		case (op_s1)
			OP_LOAD: begin
				res_sat = ld_sat;
			end
			OP_ROT: begin
				res_sat = rot_sat;
			end
			OP_MUL, OP_MULT: begin
				res_sat = mul_sat;
				is_mul = 1'b1;
			end
			default: begin
				res_sat = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					mtx_q[r][c] <= (r == c) ? ONE_E : '0;
				end
			end
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				case (op_s1)
					OP_LOAD: begin
						for (int c = 0; c < DIM; c++) begin
							mtx_q[row_s1][c] <= ld_val[c];
						end
					end
					OP_ZERO: begin
						for (int r = 0; r < DIM; r++) begin
							for (int c = 0; c < DIM; c++) begin
								mtx_q[r][c] <= '0;
							end
						end
					end
					OP_IDENT: begin
						for (int r = 0; r < DIM; r++) begin
							for (int c = 0; c < DIM; c++) begin
								mtx_q[r][c] <= (r == c) ? ONE_E : '0;
							end
						end
					end
					OP_ROT: begin
						for (int r = 0; r < DIM; r++) begin
							for (int c = 0; c < DIM; c++) begin
								mtx_q[r][c] <= rot_new[r][c];
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= in_cmd.op;
			row_s1 <= in_cmd.row;
			inv_s1 <= in_cmd.inv;
			vec_s1 <= vin;
			prod_s1 <= prod;
		end
		if (adv) begin
			for (int i = 0; i < DIM; i++) begin
				out_q[i] <= is_mul ? mul_out[i] : '0;
			end
			sat_q <= res_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign out_x = out_q[0];
	assign out_y = out_q[1];
	assign out_z = out_q[2];
	assign saturated = sat_q;

endmodule
`default_nettype wire

// ===== sv/dcm_rotation_update_engine.sv =====
// Path: an accepted word is held in the queue, then the stage-1 product register, then the
// output register. Throughput: one word per cycle while m_tready holds no result back; a
// rotate or multiply right after a word that writes the matrix (load, zero, identity,
// rotate) waits for it to leave stage 1: the matrix read, product register, write loop.
// Reset: arst_n clears the queue and the pipeline and sets the matrix to identity.
`default_nettype none
module dcm_rotation_update_engine #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dcm_pkg::TDATA_W-1:0]   s_tdata,   // vec_x, vec_y, vec_z
	input  logic [dcm_pkg::USER_IN_W-1:0] s_tuser,   // func, row_sel
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dcm_pkg::TDATA_W-1:0]   m_tdata,   // out_x, out_y, out_z
	output logic [0:0]                    m_tuser    // saturated
);
	import dcm_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;
	logic signed [VEC_W-1:0] out_x;
	logic signed [VEC_W-1:0] out_y;
	logic signed [VEC_W-1:0] out_z;
	logic saturated;

	dcm_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	dcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	dcm_back #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pop_valid),
		.in_ready  (pop_ready),
		.in_cmd    (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.saturated (saturated)
	);

	assign m_tdata = {out_z, out_y, out_x};
	assign m_tuser = saturated;

endmodule
`default_nettype wire
